// File: hdl/view_depth_index_sorter_top_assert.svh
// ---------------------------------------------------------------------------
// view depth index sorter assertion macros
// concurrent assertion helpers shared by the sorter rtl
// ---------------------------------------------------------------------------
`ifndef VIEW_DEPTH_INDEX_SORTER_TOP_ASSERT_SVH
`define VIEW_DEPTH_INDEX_SORTER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VDIS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VDIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/vdis_pkg.sv
// ---------------------------------------------------------------------------
// view depth index sorter package
// sizes, register indexes and shared types of the sorter
// ---------------------------------------------------------------------------
package vdis_pkg;

  localparam int ROW_CELLS   = 64;
  localparam int COUNT_W     = $clog2(ROW_CELLS + 1);
  localparam int INDEX_W     = 6;
  localparam int POS_W       = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = POS_W + COEF_W;
  localparam int DEPTH_W     = 34;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_COEF_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_Z = 2'd2;

  localparam logic [COEF_W-1:0] COEF_X_RESET = 16'sd0;
  localparam logic [COEF_W-1:0] COEF_Y_RESET = 16'sd0;
  localparam logic [COEF_W-1:0] COEF_Z_RESET = 16'sd16384;

  typedef logic signed [DEPTH_W-1:0] depth_t;

  // broadcast control of the cell row
  typedef struct packed {
    logic ins_en;   // a new depth enters the row
    logic shift_en; // row moves one place towards cell 0
  } cell_ctrl_t;

endpackage

// File: hdl/vdis_depth_unit.sv
// ---------------------------------------------------------------------------
// view depth unit
// two-stage pipeline: three products, then their exact 34-bit sum
// ---------------------------------------------------------------------------
module vdis_depth_unit
  import vdis_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_last,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic signed [COEF_W-1:0] coef_x,
  input  logic signed [COEF_W-1:0] coef_y,
  input  logic signed [COEF_W-1:0] coef_z,
  output logic                     out_valid,
  output logic                     out_last,
  output depth_t                   out_depth
);

  logic                     prod_valid;
  logic                     prod_last;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  depth_t                   depth_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_x    <= coef_x * pos_x;
    prod_y    <= coef_y * pos_y;
    prod_z    <= coef_z * pos_z;
    prod_last <= in_last;
    out_depth <= depth_next;
    out_last  <= prod_last;
  end

  always_comb begin
    depth_next = DEPTH_W'(prod_x) + DEPTH_W'(prod_y) + DEPTH_W'(prod_z);
  end

endmodule

// File: hdl/vdis_sort_cell.sv
// ---------------------------------------------------------------------------
// sort cell
// one place of the insertion-sorting row: depth and arrival index
// ---------------------------------------------------------------------------
module vdis_sort_cell
  import vdis_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               occ,
  input  logic               gt_left,
  input  depth_t             new_depth,
  input  logic [INDEX_W-1:0] new_index,
  input  depth_t             left_depth,
  input  logic [INDEX_W-1:0] left_index,
  input  depth_t             right_depth,
  input  logic [INDEX_W-1:0] right_index,
  output logic               gt,
  output depth_t             depth,
  output logic [INDEX_W-1:0] index
);

  // strict compare keeps equal depths ahead of the newcomer
  assign gt = occ && (depth > new_depth);

  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (gt_left) begin
        depth <= left_depth;
        index <= left_index;
      end else if (gt || !occ) begin
        depth <= new_depth;
        index <= new_index;
      end
    end else if (ctrl.shift_en) begin
      depth <= right_depth;
      index <= right_index;
    end
  end

endmodule

// File: hdl/view_depth_index_sorter_top.sv
// ---------------------------------------------------------------------------
// view depth index sorter
// depth of each splat from the view row, sorted back to front on the fly
// ---------------------------------------------------------------------------
// Each accepted splat's depth leaves a two-stage multiply and add pipeline
// and drops into a row of 64 sort cells, so a set loads at one splat per
// cycle. The splat marked with tlast closes the set: input stays stalled
// until the whole sorted run has been delivered, one index per cycle from
// cell 0 while m_tready is high and the row shifts down. Ties come out
// lowest arrival index first; splats beyond 64 are discarded and tuser is
// raised on every result of that run.
module view_depth_index_sorter_top
  import vdis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]      cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [3*POS_W-1:0]     s_tdata,   // pos_x, pos_y, pos_z
  input  logic                   s_tlast,   // last_item
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // sorted_index, zero padding
  output logic                   m_tlast,   // last_result
  output logic                   m_tuser    // dropped
);

  logic signed [COEF_W-1:0] coef_x;
  logic signed [COEF_W-1:0] coef_y;
  logic signed [COEF_W-1:0] coef_z;

  logic                 busy;
  logic                 emit;
  logic                 overflow;
  logic [COUNT_W-1:0]   count;
  logic                 in_txn;
  logic                 out_txn;

  logic                 dv_valid;
  logic                 dv_last;
  depth_t               dv_depth;

  cell_ctrl_t           ctrl;
  logic [ROW_CELLS-1:0] occ;
  logic [ROW_CELLS-1:0] gt;
  depth_t               cell_depth [ROW_CELLS];
  logic [INDEX_W-1:0]   cell_index [ROW_CELLS];
  logic                 full;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign in_txn    = s_tvalid && s_tready;
  assign out_txn   = m_tvalid && m_tready;
  assign full      = (count == COUNT_W'(ROW_CELLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x <= COEF_X_RESET;
      coef_y <= COEF_Y_RESET;
      coef_z <= COEF_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_X: coef_x <= cfg_data;
        REG_COEF_Y: coef_y <= cfg_data;
        REG_COEF_Z: coef_z <= cfg_data;
        default: ;
      endcase
    end
  end

  vdis_depth_unit u_depth (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_txn),
    .in_last   (s_tlast),
    .pos_x     (s_tdata[POS_W-1:0]),
    .pos_y     (s_tdata[2*POS_W-1:POS_W]),
    .pos_z     (s_tdata[3*POS_W-1:2*POS_W]),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .coef_z    (coef_z),
    .out_valid (dv_valid),
    .out_last  (dv_last),
    .out_depth (dv_depth)
  );

  always_comb begin
    ctrl.ins_en   = dv_valid && !full;
    ctrl.shift_en = out_txn;
  end

  genvar i;
  generate
    for (i = 0; i < ROW_CELLS; i++) begin : g_cell
      assign occ[i] = (COUNT_W'(i) < count);

      vdis_sort_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (occ[i]),
        .gt_left     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
        .new_depth   (dv_depth),
        .new_index   (count[INDEX_W-1:0]),
        .left_depth  (cell_depth[(i == 0) ? 0 : i-1]),
        .left_index  (cell_index[(i == 0) ? 0 : i-1]),
        .right_depth (cell_depth[(i == ROW_CELLS-1) ? i : i+1]),
        .right_index (cell_index[(i == ROW_CELLS-1) ? i : i+1]),
        .gt          (gt[i]),
        .depth       (cell_depth[i]),
        .index       (cell_index[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      emit     <= 1'b0;
      overflow <= 1'b0;
      count    <= '0;
    end else begin
      if (in_txn && s_tlast) begin
        busy <= 1'b1;
      end
      if (dv_valid) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + COUNT_W'(1);
        end
        if (dv_last) begin
          emit <= 1'b1;
        end
      end
      if (out_txn) begin
        count <= count - COUNT_W'(1);
        if (count == COUNT_W'(1)) begin
          emit     <= 1'b0;
          overflow <= 1'b0;
          busy     <= 1'b0;
        end
      end
    end
  end

  assign m_tvalid = emit;
  assign m_tdata  = {{(8-INDEX_W){1'b0}}, cell_index[0]};
  assign m_tlast  = (count == COUNT_W'(1));
  assign m_tuser  = overflow;

`include "view_depth_index_sorter_top_assert.svh"

  `VDIS_ASSERT_IMPL(a_emit_stalls_input, clk, rst, m_tvalid, !s_tready,
    "input accepted while the sorted run is out")
  `VDIS_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= COUNT_W'(ROW_CELLS),
    "fill count beyond the row")
  `VDIS_ASSERT_IMPL(a_emit_not_empty, clk, rst, m_tvalid, count != '0,
    "result offered from an empty row")
  `VDIS_ASSERT_NEXT(a_run_ends, clk, rst, out_txn && m_tlast,
    !m_tvalid && count == '0 && !m_tuser, "row not cleared after last transaction")

endmodule
